// ----- design/scc_pkg.sv -----
// Shared types and constants for the segment scale compensation table.
// No dependencies; used by scc_lookup and the top level.
package scc_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int ID_W           = 8;
  localparam int FLAG_W         = 32;
  localparam int SCALE_W        = 32;
  localparam int INV_W          = 3 * SCALE_W;

  // Result flag bits
  localparam logic [FLAG_W-1:0] FLAG_SCALE_ONE  = 32'h0000_0001;
  localparam logic [FLAG_W-1:0] FLAG_EX0_ONE    = 32'h0000_0008;
  localparam logic [FLAG_W-1:0] FLAG_READY      = 32'h0000_0010;
  localparam logic [FLAG_W-1:0] FLAG_COMPENSATE = 32'h0000_0020;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [INV_W-1:0]   inv_t;

  // Request into the table: store of this node, read of the parent
  typedef struct packed {
    logic go;
    logic store;
    logic skip;
    id_t  node_id;
    id_t  parent_id;
    inv_t inv;
  } lkp_req_t;

  // Parent lookup answer, valid the cycle after go and held until next go
  typedef struct packed {
    logic parent_one;
    inv_t parent_inv;
  } lkp_rsp_t;

endpackage

// ----- design/scc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Read-first on an address collision. No dependencies.
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/scc_lookup.sv -----
// Per-node scale-is-one map and inverse scale table, with same-step forwarding.
// Depends on scc_pkg and scc_ram.
module scc_lookup #(
  parameter int NODE_COUNT = scc_pkg::NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scc_pkg::lkp_req_t req,
  output scc_pkg::lkp_rsp_t rsp
);
  import scc_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [ID_W:0] NODE_LIM = (ID_W+1)'(NODE_COUNT);

  logic          node_ok;
  logic          parent_ok;
  logic [AW-1:0] naddr;
  logic [AW-1:0] paddr;
  logic          map_we;
  logic          inv_we;
  logic [0:0]    map_rdata;
  inv_t          inv_rdata;

  logic [NODE_COUNT-1:0] vld_r, vld_nxt;
  logic pok_r, pvld_r, fwd_r, fwd_skip_r;
  inv_t fwd_inv_r;

  assign node_ok   = {1'b0, req.node_id} < NODE_LIM;
  assign parent_ok = {1'b0, req.parent_id} < NODE_LIM;
  assign naddr     = req.node_id[AW-1:0];
  assign paddr     = req.parent_id[AW-1:0];
  assign map_we    = req.go && req.store && node_ok;
  assign inv_we    = map_we && !req.skip;

  scc_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (naddr),
    .wdata (req.skip),
    .re    (req.go),
    .raddr (paddr),
    .rdata (map_rdata)
  );

  scc_ram #(.WIDTH(INV_W), .DEPTH(NODE_COUNT)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (naddr),
    .wdata (req.inv),
    .re    (req.go),
    .raddr (paddr),
    .rdata (inv_rdata)
  );

  // Mark an entry of the map as written
  always_comb begin
    vld_nxt = vld_r;
    if (map_we) begin
      vld_nxt[naddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fwd_r <= 1'b0;
      pok_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.go) begin
        fwd_r <= map_we && (req.parent_id == req.node_id);
        pok_r <= parent_ok;
      end
    end
  end

  // Capture with the read; hold while the consumer waits
  always_ff @(posedge clk) begin
    if (req.go) begin
      pvld_r     <= parent_ok && vld_r[paddr];
      fwd_skip_r <= req.skip;
      fwd_inv_r  <= req.inv;
    end
  end

  // Out-of-range parent reads as not one with a zero inverse
  assign rsp.parent_one = pok_r && (fwd_r ? fwd_skip_r : (pvld_r && map_rdata[0]));
  assign rsp.parent_inv = !pok_r ? '0 :
                          ((fwd_r && !fwd_skip_r) ? fwd_inv_r : inv_rdata);

endmodule

// ----- design/segment_scale_comp_table_top.sv -----
// Segment scale compensation table: top level with handshake and result stage.
// Depends on scc_pkg and scc_lookup (which uses scc_ram).
//
// Usage:
//   One request per joint on the in_ channel (valid/stall), parents before
//   children. A request may store this joint's scale state (one-bit, or the
//   inverse scale) and may fetch its parent's state for compensation.
//   One result per request leaves on the out_ channel (valid/stall).
//   An accepted request is registered in the lookup stage, then in the result
//   stage on the out_ ports. One request per cycle while out_stall is low;
//   the store and the parent read share the same cycle of the table RAMs, and
//   a parent read of the node written by the same request is forwarded.
//   The per-node one-bit map lives in a RAM plus one valid flip-flop per node;
//   reset clears the valid bits at once, so no clearing pass is needed and
//   requests are taken from the first cycle after reset.
//   The inverse scale table is not cleared; reading a never-written entry
//   gives an undefined value.
//   When the receiver stalls, the result holds on the out_ ports, one more
//   request is taken into the lookup stage, and then in_stall rises until
//   the result is taken.
module segment_scale_comp_table_top #(
  parameter int NODE_COUNT = scc_pkg::NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_prior_flag,
  input  scc_pkg::id_t          in_node_id,
  input  scc_pkg::id_t          in_parent_id,
  input  logic                  in_has_parent,
  input  logic                  in_store_scale,
  input  logic                  in_skip_scale,
  input  logic signed [31:0]    in_scale_x,
  input  logic signed [31:0]    in_scale_y,
  input  logic signed [31:0]    in_scale_z,
  input  logic signed [31:0]    in_inv_x,
  input  logic signed [31:0]    in_inv_y,
  input  logic signed [31:0]    in_inv_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_flag_out,
  output logic signed [31:0]    out_scale_x,
  output logic signed [31:0]    out_scale_y,
  output logic signed [31:0]    out_scale_z,
  output logic signed [31:0]    out_parent_inv_x,
  output logic signed [31:0]    out_parent_inv_y,
  output logic signed [31:0]    out_parent_inv_z
);
  import scc_pkg::*;

  lkp_req_t req;
  lkp_rsp_t rsp;

  logic in_acc;
  logic s1_adv;

  // Lookup stage: request waiting for its table read
  logic                s1_vld_r;
  logic [FLAG_W-1:0]   s1_flag_r;
  logic                s1_hp_r;
  logic [3*SCALE_W-1:0] s1_scale_r;

  // Result stage
  logic                out_vld_r;
  logic [FLAG_W-1:0]   out_flag_r, out_flag_nxt;
  logic [3*SCALE_W-1:0] out_scale_r;
  inv_t                out_pinv_r, out_pinv_nxt;

  // Advance the lookup stage when the result stage is free or drains
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign req.go        = in_acc;
  assign req.store     = in_store_scale;
  assign req.skip      = in_skip_scale;
  assign req.node_id   = in_node_id;
  assign req.parent_id = in_parent_id;
  assign req.inv       = {in_inv_z, in_inv_y, in_inv_x};

  scc_lookup #(.NODE_COUNT(NODE_COUNT)) u_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Fold the parent answer into the flag word; drop the inverse if not fetched or the parent is one
  always_comb begin
    out_flag_nxt = s1_flag_r;
    out_pinv_nxt = '0;
    if (s1_hp_r) begin
      out_flag_nxt = out_flag_nxt | FLAG_COMPENSATE;
      if (rsp.parent_one) begin
        out_flag_nxt = out_flag_nxt | FLAG_EX0_ONE;
      end else begin
        out_pinv_nxt = rsp.parent_inv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flag_r  <= in_prior_flag | FLAG_READY | (in_skip_scale ? FLAG_SCALE_ONE : '0);
      s1_hp_r    <= in_has_parent;
      s1_scale_r <= in_skip_scale ? '0 : {in_scale_z, in_scale_y, in_scale_x};
    end
    if (s1_adv) begin
      out_flag_r  <= out_flag_nxt;
      out_scale_r <= s1_scale_r;
      out_pinv_r  <= out_pinv_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_flag_out     = out_flag_r;
  assign out_scale_x      = out_scale_r[SCALE_W-1:0];
  assign out_scale_y      = out_scale_r[2*SCALE_W-1:SCALE_W];
  assign out_scale_z      = out_scale_r[3*SCALE_W-1:2*SCALE_W];
  assign out_parent_inv_x = out_pinv_r[SCALE_W-1:0];
  assign out_parent_inv_y = out_pinv_r[2*SCALE_W-1:SCALE_W];
  assign out_parent_inv_z = out_pinv_r[3*SCALE_W-1:2*SCALE_W];

  // Input stalls only behind a held lookup stage
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("in_stall without a pending lookup");

  // A held lookup stage keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> s1_vld_r)
    else $error("pending lookup lost while stalled");

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_flag_out) && $stable(out_pinv_r)))
    else $error("stalled result changed");

  // Without compensation no parent inverse leaves the block, and the ready flag is set
  a_nocomp_pinv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_flag_out & FLAG_COMPENSATE) == '0)) |->
      (out_pinv_r == '0) && ((out_flag_out & FLAG_READY) != '0))
    else $error("parent inverse without compensation");

endmodule
